### src/assert_macros.svh
// assertion macros shared by the sampler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while rst is high
`define ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// consequent a fixed number of cycles after the antecedent
`define ASSERT_DELAY(label, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("%m: delayed check failed");

`endif

### src/bps_pkg.sv
// shared types and constants for the bilinear pixel sampler
package bps_pkg;

  localparam int COORD_W  = 24;
  localparam int PIX_W    = 16;
  localparam int VALUE_W  = 25;
  localparam int OUT_FRAC = 8;
  localparam int REG_W    = 16;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_INTERP_MODE,
    REG_SAMPLE_FORMAT
  } cfg_reg_t;

  localparam logic [1:0] FMT_U8  = 2'd0;
  localparam logic [1:0] FMT_S16 = 2'd1;
  localparam logic [1:0] FMT_U16 = 2'd2;

  localparam logic MODE_NEAREST  = 1'b0;
  localparam logic MODE_BILINEAR = 1'b1;

  typedef struct packed {
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
    logic [PIX_W-1:0]   pix_top_left;
    logic [PIX_W-1:0]   pix_top_right;
    logic [PIX_W-1:0]   pix_bottom_left;
    logic [PIX_W-1:0]   pix_bottom_right;
  } sample_req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sample_value;
    logic                      status;
    logic                      on_border;
    logic                      used_fallback;
  } sample_rsp_t;

  typedef struct packed {
    logic [REG_W-1:0] image_width;
    logic [REG_W-1:0] image_height;
    logic             interp_mode;
    logic [1:0]       sample_format;
  } cfg_t;

  typedef struct packed {
    logic outside;
    logic border;
    logic use_target;
    logic fallback;
  } flags_t;

endpackage

### src/bps_front.sv
// front stage: coordinate split, edge checks, sample decode and weights
module bps_front #(
  parameter int F  = 8,
  parameter int SB = 16
) (
  input  logic                clk,
  input  bps_pkg::sample_req_t req,
  input  bps_pkg::cfg_t       cfg,
  output logic signed [SB:0]  smp [4],
  output logic signed [SB:0]  target,
  output logic [F:0]          wx,
  output logic [F:0]          wxc,
  output logic [F:0]          wy,
  output logic [F:0]          wyc,
  output bps_pkg::flags_t     flags
);
  import bps_pkg::*;

  localparam int XW = COORD_W - F;
  localparam int CW = ((XW > REG_W) ? XW : REG_W) + 1;
  localparam logic [F:0] ONE  = {1'b1, {F{1'b0}}};
  localparam logic [F:0] HALF = {2'b01, {(F-1){1'b0}}};

  function automatic logic signed [SB:0] decode(input logic [PIX_W-1:0] raw,
                                                input logic [1:0] fmt);
    logic signed [SB:0] v;
    case (fmt)
      FMT_U8:  v = $signed({{(SB-7){1'b0}}, raw[7:0]});
      FMT_S16: v = $signed({raw[SB-1], raw[SB-1:0]});
      default: v = $signed({1'b0, raw[SB-1:0]});
    endcase
    return v;
  endfunction

  logic [XW-1:0]      xt, yt;
  logic [F-1:0]       fx, fy;
  logic [CW-1:0]      xt_c, yt_c, w_c, h_c;
  logic               last_x, last_y, x_lo, y_lo, x_hi, y_hi, buildable;
  logic [F:0]         wx_c, wy_c;
  logic signed [SB:0] smp_c [4];
  flags_t             flags_c;

  always_comb begin
    xt   = req.x_coord[COORD_W-1:F];
    yt   = req.y_coord[COORD_W-1:F];
    fx   = req.x_coord[F-1:0];
    fy   = req.y_coord[F-1:0];
    xt_c = CW'(xt);
    yt_c = CW'(yt);
    w_c  = CW'(cfg.image_width);
    h_c  = CW'(cfg.image_height);
    last_x = (xt_c + CW'(1)) == w_c;
    last_y = (yt_c + CW'(1)) == h_c;
    // below half: target is the right column / bottom row of the window
    x_lo = !fx[F-1];
    y_lo = !fy[F-1];
    x_hi = fx[F-1] && (|fx[F-2:0]);
    y_hi = fy[F-1] && (|fy[F-2:0]);
    buildable = !((xt == '0 && x_lo) || (yt == '0 && y_lo) ||
                  (last_x && x_hi) || (last_y && y_hi));
    flags_c.outside    = (xt_c >= w_c) || (yt_c >= h_c);
    flags_c.border     = (xt == '0) || (yt == '0) || last_x || last_y;
    flags_c.use_target = (cfg.interp_mode == MODE_NEAREST) || !buildable;
    flags_c.fallback   = (cfg.interp_mode == MODE_BILINEAR) && !buildable;
    // left column / top row weight, scaled by one
    wx_c = HALF + (x_lo ? '0 : ONE) - {1'b0, fx};
    wy_c = HALF + (y_lo ? '0 : ONE) - {1'b0, fy};
    smp_c[0] = decode(req.pix_top_left,     cfg.sample_format);
    smp_c[1] = decode(req.pix_top_right,    cfg.sample_format);
    smp_c[2] = decode(req.pix_bottom_left,  cfg.sample_format);
    smp_c[3] = decode(req.pix_bottom_right, cfg.sample_format);
  end

  always_ff @(posedge clk) begin
    smp    <= smp_c;
    target <= smp_c[{y_lo, x_lo}];
    wx     <= wx_c;
    wxc    <= ONE - wx_c;
    wy     <= wy_c;
    wyc    <= ONE - wy_c;
    flags  <= flags_c;
  end

endmodule

### src/bps_lane.sv
// one window lane: weight product, then sample times weight
module bps_lane #(
  parameter int F  = 8,
  parameter int SB = 16
) (
  input  logic                           clk,
  input  logic signed [SB:0]             smp,
  input  logic [F:0]                     wa,
  input  logic [F:0]                     wb,
  output logic signed [SB+2*F+2:0]       prod
);
  logic [2*F+1:0]     w_full;
  logic [2*F:0]       w;
  logic signed [SB:0] smp_d;

  assign w_full = wa * wb;

  always_ff @(posedge clk) begin
    // product never exceeds one squared, so the top bit is always zero
    w     <= w_full[2*F:0];
    smp_d <= smp;
    prod  <= smp_d * $signed({1'b0, w});
  end

endmodule

### src/bps_merge.sv
// merge stage: lane sum, rounding, target or outside selection
module bps_merge #(
  parameter int F  = 8,
  parameter int SB = 16
) (
  input  logic                     clk,
  input  logic signed [SB+2*F+2:0] prod [4],
  input  logic signed [SB:0]       target,
  input  bps_pkg::flags_t          flags,
  output bps_pkg::sample_rsp_t     rsp
);
  import bps_pkg::*;

  localparam int PW = SB + 2*F + 3;
  localparam int SH = 2*F - OUT_FRAC;
  localparam int AW = ((PW + 2) > (VALUE_W + SH)) ? (PW + 2) : (VALUE_W + SH);
  // half an output lsb, zero when there is nothing to shift off
  localparam logic signed [AW-1:0] RND = (AW'(1) << SH) >> 1;

  logic signed [AW-1:0]      sum, rounded, shifted;
  logic signed [VALUE_W-1:0] near_v;
  sample_rsp_t               rsp_c;

  always_comb begin
    sum     = AW'(prod[0]) + AW'(prod[1]) + AW'(prod[2]) + AW'(prod[3]);
    rounded = sum + RND;
    shifted = rounded >>> SH;
    near_v  = VALUE_W'(target) <<< OUT_FRAC;
    rsp_c.status        = flags.outside;
    rsp_c.on_border     = !flags.outside && flags.border;
    rsp_c.used_fallback = !flags.outside && flags.fallback;
    if (flags.outside) begin
      rsp_c.sample_value = '0;
    end else if (flags.use_target) begin
      rsp_c.sample_value = near_v;
    end else begin
      rsp_c.sample_value = shifted[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_c;
  end

endmodule

### src/bilinear_pixel_sampler_unit.sv
// top level of the bilinear pixel sampler
// Takes one request per clock whenever start is high (busy stays low) and
// returns its result with done high for one cycle; there is no back-pressure,
// so the receiver must take every result as it comes. The pipeline has four
// register stages: coordinate and sample decode, the per-lane weight multiply,
// the per-lane sample multiply, and the merge that sums the four lanes and
// rounds. Configuration registers may only be written while no request is in
// flight.
module bilinear_pixel_sampler_unit #(
  parameter int COORD_FRAC_BITS = 8,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  bps_pkg::sample_req_t  req,
  input  logic                  cfg_write,
  input  bps_pkg::cfg_reg_t     cfg_index,
  input  logic [15:0]           cfg_data,
  output logic                  done,
  output bps_pkg::sample_rsp_t  rsp
);
  import bps_pkg::*;
  `include "assert_macros.svh"

  localparam int F  = COORD_FRAC_BITS;
  localparam int SB = SAMPLE_BITS;
  localparam int PW = SB + 2*F + 3;

  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width   <= REG_W'(1);
      cfg.image_height  <= REG_W'(1);
      cfg.interp_mode   <= MODE_BILINEAR;
      cfg.sample_format <= FMT_U8;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:   cfg.image_width   <= cfg_data;
        REG_IMAGE_HEIGHT:  cfg.image_height  <= cfg_data;
        REG_INTERP_MODE:   cfg.interp_mode   <= cfg_data[0];
        REG_SAMPLE_FORMAT: cfg.sample_format <= cfg_data[1:0];
      endcase
    end
  end

  assign busy = 1'b0;

  logic v1, v2, v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start && !busy;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  logic signed [SB:0]   smp [4];
  logic signed [SB:0]   target1, target2, target3;
  logic [F:0]           wx, wxc, wy, wyc;
  flags_t               flags1, flags2, flags3;
  logic signed [PW-1:0] prod [4];

  bps_front #(.F(F), .SB(SB)) u_front (
    .clk    (clk),
    .req    (req),
    .cfg    (cfg),
    .smp    (smp),
    .target (target1),
    .wx     (wx),
    .wxc    (wxc),
    .wy     (wy),
    .wyc    (wyc),
    .flags  (flags1)
  );

  // lane order: top left, top right, bottom left, bottom right
  for (genvar i = 0; i < 4; i++) begin : g_lane
    bps_lane #(.F(F), .SB(SB)) u_lane (
      .clk  (clk),
      .smp  (smp[i]),
      .wa   (((i % 2) == 0) ? wx : wxc),
      .wb   ((i < 2) ? wy : wyc),
      .prod (prod[i])
    );
  end

  // target sample and flags ride alongside the two lane stages
  always_ff @(posedge clk) begin
    target2 <= target1;
    target3 <= target2;
    flags2  <= flags1;
    flags3  <= flags2;
  end

  bps_merge #(.F(F), .SB(SB)) u_merge (
    .clk    (clk),
    .prod   (prod),
    .target (target3),
    .flags  (flags3),
    .rsp    (rsp)
  );

  `ASSERT_DELAY(a_done_after_request, start && !busy, 4, done)
  `ASSERT_IMPLY(a_outside_clears, done && rsp.status,
                rsp.sample_value == '0 && !rsp.on_border && !rsp.used_fallback)
  `ASSERT_IMPLY(a_fallback_bilinear, done && rsp.used_fallback,
                cfg.interp_mode == MODE_BILINEAR)
  `ASSERT_IMPLY(a_nearest_integral, done && cfg.interp_mode == MODE_NEAREST,
                rsp.sample_value[OUT_FRAC-1:0] == '0)

endmodule

### tb/sv/testbench.sv
// self-checking testbench for the bilinear pixel sampler unit
module testbench;
  import bps_pkg::*;

  localparam int CLK_PERIOD = 20;
  localparam int COORD_FRAC = 8;
  localparam longint FRAC_ONE = longint'(1) <<< COORD_FRAC;
  localparam longint FRAC_HALF = FRAC_ONE >>> 1;
  localparam int ROUND_SHIFT = 2 * COORD_FRAC - OUT_FRAC;
  localparam logic [1:0] FMT_UNUSED = 2'd3;
  localparam int PIPE_LATENCY = 4;
  localparam int DRAIN_LIMIT = 200;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS = 50;
  localparam int RUN_LIMIT = 4000000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  sample_req_t req;
  logic cfg_write;
  cfg_reg_t cfg_index;
  logic [15:0] cfg_data;
  logic done;
  sample_rsp_t rsp;

  // local copy of the sampler registers
  logic [15:0] cur_width;
  logic [15:0] cur_height;
  logic cur_mode;
  logic [1:0] cur_format;

  sample_rsp_t pending_samples [$];
  int items_sent;
  int results_checked;
  int cfg_writes;
  int error_count;
  int reports_shown;
  int burst_left;

  bilinear_pixel_sampler_unit u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("timeout after %0d requests, %0d results", items_sent, results_checked);
    $display("testbench NOT OK");
    $finish;
  end

  function automatic longint decode_sample(input logic [15:0] raw);
    case (cur_format)
      FMT_U8: return longint'(raw[7:0]);
      FMT_S16: return longint'($signed(raw));
      default: return longint'(raw);
    endcase
  endfunction

  function automatic sample_rsp_t predict_sample(input sample_req_t r);
    sample_rsp_t o;
    longint px [4];
    logic [15:0] xt;
    logic [15:0] yt;
    longint fx;
    longint fy;
    logic right_col;
    logic bottom_row;
    logic window_ok;
    longint wx;
    longint wy;
    longint top_mix;
    longint bot_mix;
    longint value;
    o = '0;
    xt = r.x_coord[COORD_W-1:COORD_FRAC];
    yt = r.y_coord[COORD_W-1:COORD_FRAC];
    fx = longint'(r.x_coord[COORD_FRAC-1:0]);
    fy = longint'(r.y_coord[COORD_FRAC-1:0]);
    px[0] = decode_sample(r.pix_top_left);
    px[1] = decode_sample(r.pix_top_right);
    px[2] = decode_sample(r.pix_bottom_left);
    px[3] = decode_sample(r.pix_bottom_right);
    if (xt >= cur_width || yt >= cur_height) begin
      o.status = 1'b1;
      return o;
    end
    o.on_border = xt == 16'd0 || yt == 16'd0 ||
                  xt == cur_width - 16'd1 || yt == cur_height - 16'd1;
    // window origin is half a pixel up-left, so a low fraction targets the right column
    right_col = fx < FRAC_HALF;
    bottom_row = fy < FRAC_HALF;
    window_ok = !((xt == 16'd0 && fx < FRAC_HALF) || (yt == 16'd0 && fy < FRAC_HALF) ||
                  (xt == cur_width - 16'd1 && fx > FRAC_HALF) ||
                  (yt == cur_height - 16'd1 && fy > FRAC_HALF));
    if (cur_mode == MODE_NEAREST || !window_ok) begin
      value = px[{bottom_row, right_col}] * (longint'(1) <<< OUT_FRAC);
      o.used_fallback = (cur_mode == MODE_BILINEAR);
    end else begin
      // left column and top row weights
      wx = right_col ? FRAC_HALF - fx : FRAC_ONE + FRAC_HALF - fx;
      wy = bottom_row ? FRAC_HALF - fy : FRAC_ONE + FRAC_HALF - fy;
      top_mix = px[0] * wx + px[1] * (FRAC_ONE - wx);
      bot_mix = px[2] * wx + px[3] * (FRAC_ONE - wx);
      value = (top_mix * wy + bot_mix * (FRAC_ONE - wy) +
               (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
    end
    o.sample_value = value[VALUE_W-1:0];
    return o;
  endfunction

  task automatic note_failure(input string msg);
    error_count++;
    if (reports_shown < MAX_REPORTS) begin
      reports_shown++;
      $display("FAIL: %s", msg);
    end
  endtask

  task automatic report_mismatch(input string field, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
    note_failure($sformatf("result %0d, %s: expected %0d, got %0d",
                           results_checked, field, want, got));
  endtask

  // retire results and record accepted requests, in that order
  always @(posedge clk) begin : check_results
    sample_rsp_t want;
    if (!rst && done === 1'b1) begin
      if (pending_samples.size() == 0) begin
        note_failure($sformatf("result with nothing pending: value %0d status %0b",
                               rsp.sample_value, rsp.status));
      end else begin
        want = pending_samples.pop_front();
        if (rsp.sample_value !== want.sample_value)
          report_mismatch("sample_value", want.sample_value, rsp.sample_value);
        if (rsp.status !== want.status)
          report_mismatch("status", want.status, rsp.status);
        if (rsp.on_border !== want.on_border)
          report_mismatch("on_border", want.on_border, rsp.on_border);
        if (rsp.used_fallback !== want.used_fallback)
          report_mismatch("used_fallback", want.used_fallback, rsp.used_fallback);
        results_checked++;
      end
    end
    if (!rst && start === 1'b1 && busy === 1'b0) begin
      pending_samples.push_back(predict_sample(req));
      items_sent++;
    end
  end

  function automatic int pick_gap();
    int roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_sample(input sample_req_t item);
    int gap;
    gap = pick_gap();
    repeat (gap) @(negedge clk) start <= 1'b0;
    @(negedge clk);
    start <= 1'b1;
    req <= item;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    @(negedge clk) start <= 1'b0;
    while (pending_samples.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_samples.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", pending_samples.size()));
      error_count += pending_samples.size() - 1;
      pending_samples.delete();
    end
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH: cur_width = value;
      REG_IMAGE_HEIGHT: cur_height = value;
      REG_INTERP_MODE: cur_mode = value[0];
      REG_SAMPLE_FORMAT: cur_format = value[1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic configure(input logic [15:0] w, input logic [15:0] h, input logic mode,
                           input logic [1:0] fmt);
    drain_results();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_INTERP_MODE, 16'(mode));
    write_reg(REG_SAMPLE_FORMAT, 16'(fmt));
  endtask

  function automatic logic [23:0] coord(input int unsigned ip, input int unsigned fr);
    return {16'(ip), 8'(fr)};
  endfunction

  function automatic sample_req_t make_req(input logic [23:0] x, input logic [23:0] y,
                                           input logic [15:0] tl, input logic [15:0] tr,
                                           input logic [15:0] bl, input logic [15:0] br);
    sample_req_t r;
    r.x_coord = x;
    r.y_coord = y;
    r.pix_top_left = tl;
    r.pix_top_right = tr;
    r.pix_bottom_left = bl;
    r.pix_bottom_right = br;
    return r;
  endfunction

  // mostly inside the image and near its edges, some just past it, some anywhere
  function automatic logic [23:0] pick_coord(input logic [15:0] extent);
    int unsigned sel;
    int unsigned ip;
    int unsigned span;
    logic [7:0] fr;
    sel = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0: fr = 8'd0;
      1: fr = 8'(FRAC_HALF);
      2: fr = 8'(FRAC_HALF - 1);
      3: fr = 8'(FRAC_HALF + 1);
      4: fr = 8'hFF;
      default: fr = 8'($urandom);
    endcase
    span = 32'(extent);
    if (span == 0 || sel >= 92) return 24'($urandom);
    if (sel >= 82) begin
      ip = span + $urandom_range(0, 3);
      if (ip > 32'hFFFF) ip = 32'hFFFF;
    end else begin
      case ($urandom_range(0, 5))
        0: ip = 0;
        1: ip = span - 1;
        2: ip = (span > 1) ? 1 : 0;
        3: ip = (span > 1) ? span - 2 : 0;
        default: ip = $urandom_range(0, span - 1);
      endcase
    end
    return {16'(ip), fr};
  endfunction

  function automatic logic [15:0] pick_pixel();
    case ($urandom_range(0, 11))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h7FFF;
      3: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_extent();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 16'd1;
    if (roll == 1) return 16'd2;
    if (roll == 2) return 16'hFFFF;
    if (roll == 3) return 16'd0;
    if (roll < 15) return 16'($urandom_range(3, 64));
    return 16'($urandom_range(65, 65534));
  endfunction

  // 1x1 image, bilinear, 8-bit samples straight out of reset
  task automatic test_reset_values();
    send_sample(make_req(coord(0, 128), coord(0, 128), 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0));
    send_sample(make_req(coord(0, 10), coord(0, 200), 16'hFF01, 16'h0080, 16'h00FF, 16'h7F7F));
    send_sample(make_req(coord(1, 0), coord(0, 0), 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
  endtask

  task automatic test_edges_bilinear();
    configure(16'd4, 16'd3, MODE_BILINEAR, FMT_S16);
    send_sample(make_req(coord(2, 64), coord(1, 192), 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001));
    send_sample(make_req(coord(1, 0), coord(1, 0), 16'h0100, 16'h0200, 16'h0300, 16'h0400));
    send_sample(make_req(coord(1, 255), coord(1, 255), 16'hFFFF, 16'h0000, 16'h0000, 16'h0000));
    send_sample(make_req(coord(1, 128), coord(1, 128), 16'h8000, 16'h8000, 16'h8000, 16'h8000));
    send_sample(make_req(coord(2, 127), coord(1, 129), 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    // each edge where the window would leave the image
    send_sample(make_req(coord(0, 127), coord(1, 128), 16'h1111, 16'h2222, 16'h3333, 16'h4444));
    send_sample(make_req(coord(3, 129), coord(1, 64), 16'h1111, 16'h2222, 16'h3333, 16'h4444));
    send_sample(make_req(coord(2, 100), coord(0, 100), 16'h1111, 16'h2222, 16'h3333, 16'h4444));
    send_sample(make_req(coord(1, 50), coord(2, 200), 16'h1111, 16'h2222, 16'h3333, 16'h4444));
    // exactly half on the last column and row keeps the window
    send_sample(make_req(coord(3, 128), coord(2, 128), 16'hABCD, 16'h5555, 16'h0F0F, 16'hF0F0));
    send_sample(make_req(coord(4, 0), coord(0, 0), 16'h1234, 16'h1234, 16'h1234, 16'h1234));
    send_sample(make_req(coord(0, 0), coord(3, 255), 16'h1234, 16'h1234, 16'h1234, 16'h1234));
    send_sample(make_req(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
  endtask

  task automatic test_nearest_mode();
    configure(16'd5, 16'd5, MODE_NEAREST, FMT_U16);
    send_sample(make_req(coord(2, 30), coord(2, 220), 16'h0102, 16'h0304, 16'h0506, 16'h0708));
    send_sample(make_req(coord(0, 10), coord(4, 250), 16'h0102, 16'h0304, 16'h0506, 16'h0708));
    send_sample(make_req(coord(3, 200), coord(1, 5), 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_sample(make_req(coord(2, 0), coord(5, 0), 16'h0102, 16'h0304, 16'h0506, 16'h0708));
  endtask

  task automatic test_sample_formats();
    configure(16'd8, 16'd8, MODE_BILINEAR, FMT_U8);
    send_sample(make_req(coord(3, 77), coord(4, 150), 16'hFF80, 16'h12FF, 16'h8001, 16'hAB7F));
    drain_results();
    write_reg(REG_SAMPLE_FORMAT, 16'(FMT_UNUSED));
    send_sample(make_req(coord(3, 77), coord(4, 150), 16'hFFFF, 16'h8000, 16'h0001, 16'h7FFF));
    drain_results();
    write_reg(REG_SAMPLE_FORMAT, 16'(FMT_S16));
    // mixed signs so the rounding lands on both sides of zero
    send_sample(make_req(coord(5, 191), coord(2, 1), 16'hFFFF, 16'h0000, 16'hFFFE, 16'h0001));
  endtask

  task automatic test_degenerate_sizes();
    configure(16'd0, 16'd6, MODE_BILINEAR, FMT_U16);
    send_sample(make_req(coord(0, 0), coord(0, 0), 16'h1111, 16'h2222, 16'h3333, 16'h4444));
    configure(16'd6, 16'd0, MODE_BILINEAR, FMT_U16);
    send_sample(make_req(coord(0, 0), coord(0, 0), 16'h1111, 16'h2222, 16'h3333, 16'h4444));
    configure(16'hFFFF, 16'hFFFF, MODE_BILINEAR, FMT_U16);
    send_sample(make_req(coord(65534, 200), coord(65534, 128), 16'h0F0F, 16'hF0F0, 16'h00FF,
                         16'hFF00));
    send_sample(make_req(coord(65534, 128), coord(65533, 40), 16'hFFFF, 16'h8000, 16'h7FFF,
                         16'h0000));
    send_sample(make_req(coord(65535, 0), coord(0, 0), 16'h1111, 16'h2222, 16'h3333, 16'h4444));
  endtask

  task automatic test_random_phases();
    logic [15:0] w;
    logic [15:0] h;
    logic mode;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      w = pick_extent();
      h = pick_extent();
      mode = ($urandom_range(0, 3) == 0) ? MODE_NEAREST : MODE_BILINEAR;
      configure(w, h, mode, 2'($urandom_range(0, 3)));
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_sample(make_req(pick_coord(w), pick_coord(h), pick_pixel(), pick_pixel(),
                             pick_pixel(), pick_pixel()));
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_write = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_data = '0;
    cur_width = 16'd1;
    cur_height = 16'd1;
    cur_mode = MODE_BILINEAR;
    cur_format = FMT_U8;
    items_sent = 0;
    results_checked = 0;
    cfg_writes = 0;
    error_count = 0;
    reports_shown = 0;
    burst_left = 0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_reset_values();
    test_edges_bilinear();
    test_nearest_mode();
    test_sample_formats();
    test_degenerate_sizes();
    test_random_phases();
    drain_results();

    $display("sampled %0d coordinates across %0d register writes, %0d results compared",
             items_sent, cfg_writes, results_checked);
    $display("failures counted: %0d", error_count);
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/bps_pkg.sv
src/bps_front.sv
src/bps_lane.sv
src/bps_merge.sv
src/bilinear_pixel_sampler_unit.sv
tb/sv/testbench.sv
